// File: hw/rtl/nearest_palette_color_search_unit_defines.svh
// Assertion macros for the nearest palette color search unit.
// Expect signals clk and rst_n in the scope of each use.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_UNIT_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define NPCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NPCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NPCS_ASSERT_IMP(lbl, ante, cons)
`define NPCS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/npcs_pkg.sv
// Types and constants shared by the nearest palette color search unit.
// No dependencies.
package npcs_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned ENTRY_W  = 3 * CHAN_W;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT = 1'b1;

  localparam logic [CHAN_W-1:0]  MAX_DISTANCE_RST  = 8'd21;
  localparam logic [COUNT_W-1:0] PALETTE_COUNT_RST = 9'd0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PUSH
  } state_t;

endpackage

// File: hw/rtl/npcs_if.sv
// Valid/ready channel interfaces for query/write items and results.
// Depends on npcs_pkg for field widths.
interface npcs_in_if
  import npcs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [IDX_W-1:0]  entry_index;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, cmd, entry_index, red, green, blue, input ready);
  modport sink   (input valid, cmd, entry_index, red, green, blue, output ready);
endinterface

interface npcs_out_if
  import npcs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              found;
  logic [IDX_W-1:0]  match_index;
  logic [CHAN_W-1:0] match_distance;

  modport source (output valid, found, match_index, match_distance, input ready);
  modport sink   (input valid, found, match_index, match_distance, output ready);
endinterface

// File: hw/rtl/nearest_palette_color_search_unit.sv
// Nearest palette color search: palette RAM, scan sequencer and result register.
// Depends on npcs_pkg, npcs_if, npcs_ram and the assertion macro header.
//
// Usage:
//   in_ch carries items: cmd = write stores {red, green, blue} at entry_index
//   (ignored at or above the palette depth) and gives no result; cmd = query
//   scans entries 0 .. min(palette_count, depth, 256) - 1 and gives one result
//   on out_ch: found, match_index and match_distance (Chebyshev distance).
//   cfg_we/cfg_index/cfg_wdata write max_distance (index 0) and
//   palette_count (index 1); write them only while the unit is idle.
//   An empty palette skips the scan, and an exact match ends the scan early;
//   the scan reads one palette entry per cycle from the RAM read port.
//   in_ch.ready is high only while no scan runs and no result waits to enter
//   the output register; a held result does not block writes or a new query.
//   When the receiver stalls, the finished result waits in the sequencer
//   until the output register frees up.
//   Reset (rst_n low at a clock edge) sets max_distance to 21, palette_count
//   to 0 and empties the channels; palette contents stay undefined until
//   written.
`include "nearest_palette_color_search_unit_defines.svh"

module nearest_palette_color_search_unit
  import npcs_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  npcs_in_if.sink               in_ch,
  npcs_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned MEM_DEPTH = (PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256;
  localparam int unsigned ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [COUNT_W-1:0] LIMIT_MAX = COUNT_W'(MEM_DEPTH);

  state_t             state_r, state_nxt;
  logic [CHAN_W-1:0]  max_distance_r;
  logic [COUNT_W-1:0] palette_count_r;

  logic [CHAN_W-1:0]  q_red_r, q_green_r, q_blue_r;
  logic [CHAN_W-1:0]  q_red_nxt, q_green_nxt, q_blue_nxt;
  logic [COUNT_W-1:0] limit_r, limit_nxt;
  logic [COUNT_W-1:0] issue_cnt_r, issue_cnt_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               best_ok_r, best_ok_nxt;
  logic [CHAN_W-1:0]  best_dist_r, best_dist_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [IDX_W-1:0]   out_index_r, out_index_nxt;
  logic [CHAN_W-1:0]  out_dist_r, out_dist_nxt;

  logic               in_xfer;
  logic [COUNT_W-1:0] count_lim;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [CHAN_W-1:0]  d_red, d_green, d_blue, d_max;
  logic               take;
  logic               last;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign count_lim   = (palette_count_r > LIMIT_MAX) ? LIMIT_MAX : palette_count_r;

  // Writes land only while idle; read data is used only while scanning: no overlap.
  assign ram_we    = in_xfer && (in_ch.cmd == CMD_WRITE)
                     && ({1'b0, in_ch.entry_index} < LIMIT_MAX);
  assign ram_waddr = in_ch.entry_index[ADDR_W-1:0];
  assign ram_wdata = {in_ch.red, in_ch.green, in_ch.blue};
  assign ram_raddr = issue_cnt_r[ADDR_W-1:0];

  npcs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MEM_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Chebyshev distance of the entry that returned from the RAM.
  always_comb begin
    logic [CHAN_W-1:0] e_red, e_green, e_blue;
    e_red   = ram_rdata[ENTRY_W-1 -: CHAN_W];
    e_green = ram_rdata[2*CHAN_W-1 -: CHAN_W];
    e_blue  = ram_rdata[CHAN_W-1:0];
    d_red   = (q_red_r   > e_red)   ? q_red_r   - e_red   : e_red   - q_red_r;
    d_green = (q_green_r > e_green) ? q_green_r - e_green : e_green - q_green_r;
    d_blue  = (q_blue_r  > e_blue)  ? q_blue_r  - e_blue  : e_blue  - q_blue_r;
    d_max   = (d_green > d_red) ? d_green : d_red;
    d_max   = (d_blue > d_max) ? d_blue : d_max;
  end

  assign take = cmp_vld_r && (d_max <= max_distance_r)
                && (!best_ok_r || (d_max <= best_dist_r));
  assign last = cmp_vld_r && (({1'b0, cmp_idx_r} == (limit_r - 1'b1))
                              || (take && (d_max == '0)));

  always_comb begin
    state_nxt     = state_r;
    q_red_nxt     = q_red_r;
    q_green_nxt   = q_green_r;
    q_blue_nxt    = q_blue_r;
    limit_nxt     = limit_r;
    issue_cnt_nxt = issue_cnt_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    best_ok_nxt   = best_ok_r;
    best_dist_nxt = best_dist_r;
    best_idx_nxt  = best_idx_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_index_nxt = out_index_r;
    out_dist_nxt  = out_dist_r;

    // Drop the held result once the receiver takes it.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_ch.cmd == CMD_QUERY)) begin
          q_red_nxt     = in_ch.red;
          q_green_nxt   = in_ch.green;
          q_blue_nxt    = in_ch.blue;
          limit_nxt     = count_lim;
          issue_cnt_nxt = '0;
          best_ok_nxt   = 1'b0;
          best_dist_nxt = '0;
          best_idx_nxt  = '0;
          state_nxt     = (count_lim == '0) ? S_PUSH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue_cnt_r < limit_r) begin
          issue_cnt_nxt = issue_cnt_r + 1'b1;
          cmp_vld_nxt   = 1'b1;
          cmp_idx_nxt   = issue_cnt_r[IDX_W-1:0];
        end
        if (take) begin
          best_ok_nxt   = 1'b1;
          best_dist_nxt = d_max;
          best_idx_nxt  = cmp_idx_r;
        end
        if (last) begin
          // The read issued past an exact match is dropped here.
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = best_ok_r;
          out_index_nxt = best_ok_r ? best_idx_r : '0;
          out_dist_nxt  = best_ok_r ? best_dist_r : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      best_ok_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      best_ok_r   <= best_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_distance_r  <= MAX_DISTANCE_RST;
      palette_count_r <= PALETTE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_DISTANCE:  max_distance_r  <= cfg_wdata[CHAN_W-1:0];
        CFG_PALETTE_COUNT: palette_count_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    q_red_r     <= q_red_nxt;
    q_green_r   <= q_green_nxt;
    q_blue_r    <= q_blue_nxt;
    limit_r     <= limit_nxt;
    issue_cnt_r <= issue_cnt_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    best_dist_r <= best_dist_nxt;
    best_idx_r  <= best_idx_nxt;
    out_found_r <= out_found_nxt;
    out_index_r <= out_index_nxt;
    out_dist_r  <= out_dist_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.found          = out_found_r;
  assign out_ch.match_index    = out_index_r;
  assign out_ch.match_distance = out_dist_r;

  `NPCS_ASSERT_IMP(a_not_found_zero, out_valid_r && !out_found_r,
                   (out_index_r == '0) && (out_dist_r == '0))
  `NPCS_ASSERT_IMP(a_cmp_in_range, cmp_vld_r && (state_r == S_SCAN),
                   {1'b0, cmp_idx_r} < limit_r)
  `NPCS_ASSERT_IMP(a_best_in_limit, best_ok_r && (state_r != S_IDLE),
                   best_dist_r <= max_distance_r)
  `NPCS_ASSERT_NXT(a_empty_query, in_xfer && (in_ch.cmd == CMD_QUERY) && (count_lim == '0),
                   state_r == S_PUSH)

endmodule

// File: hw/rtl/npcs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module npcs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: test/tb_nearest_palette_color_search_unit.sv
`timescale 1ns / 1ps
// Testbench for the nearest palette color search unit: a directed table, then random
// phases of palette writes and queries, checked by the table or a local search model.
// Depends on npcs_pkg, npcs_if and nearest_palette_color_search_unit.
module tb_nearest_palette_color_search_unit;
  import npcs_pkg::*;

  localparam int unsigned DEPTH         = 256;
  localparam int unsigned ITEM_TARGET   = 1050;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 20;

  typedef struct packed {
    logic              cmd;
    logic [IDX_W-1:0]  idx;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  index;
    logic [CHAN_W-1:0] distance;
  } match_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    item_t                 item;
    logic                  typed;
    match_t                want;
  } row_t;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_TOGGLE, RDY_RANDOM, RDY_HOLD_OFF} rdy_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  npcs_in_if  in_ch ();
  npcs_out_if out_ch ();

  nearest_palette_color_search_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Local copy of the palette and the two registers
  logic [ENTRY_W-1:0] pal_rgb [DEPTH];
  logic [CHAN_W-1:0]  thresh = MAX_DISTANCE_RST;
  logic [COUNT_W-1:0] in_use = PALETTE_COUNT_RST;
  match_t             pending_q [$];

  int unsigned mismatches = 0;
  int unsigned n_items    = 0;
  int unsigned n_results  = 0;
  int unsigned n_found    = 0;
  int unsigned burst_left = 0;
  int unsigned quiet      = 0;

  row_t steps [$];

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int unsigned chan_gap(input logic [CHAN_W-1:0] a,
                                           input logic [CHAN_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Scan the entries in use; ties go to the later entry, an exact hit ends the scan
  function automatic match_t nearest_entry(input logic [CHAN_W-1:0] r,
                                           input logic [CHAN_W-1:0] g,
                                           input logic [CHAN_W-1:0] b);
    match_t             res;
    logic [ENTRY_W-1:0] e;
    int unsigned        span, best, d, i;
    res  = '0;
    best = 256;
    span = (in_use > DEPTH) ? DEPTH : in_use;
    i    = 0;
    while (i < span && !(res.found && best == 0)) begin
      e = pal_rgb[i[IDX_W-1:0]];
      d = chan_gap(r, e[2*CHAN_W +: CHAN_W]);
      if (chan_gap(g, e[CHAN_W +: CHAN_W]) > d) d = chan_gap(g, e[CHAN_W +: CHAN_W]);
      if (chan_gap(b, e[0 +: CHAN_W]) > d) d = chan_gap(b, e[0 +: CHAN_W]);
      if (d <= thresh && d <= best) begin
        best         = d;
        res.found    = 1'b1;
        res.index    = i[IDX_W-1:0];
        res.distance = d[CHAN_W-1:0];
      end
      i++;
    end
    return res;
  endfunction

  function automatic logic [CHAN_W-1:0] nudge(input logic [CHAN_W-1:0] c,
                                              input int unsigned span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - int'(span);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[CHAN_W-1:0];
  endfunction

  function automatic row_t item_row(input logic cmd, input logic [IDX_W-1:0] idx,
                                    input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                                    input logic [CHAN_W-1:0] b);
    row_t row;
    row      = '0;
    row.kind = ROW_ITEM;
    row.item = '{cmd, idx, r, g, b};
    return row;
  endfunction

  function automatic row_t typed_row(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                                     input logic [CHAN_W-1:0] b, input logic found,
                                     input logic [IDX_W-1:0] index,
                                     input logic [CHAN_W-1:0] distance);
    row_t row;
    row       = item_row(CMD_QUERY, '0, r, g, b);
    row.typed = 1'b1;
    row.want  = '{found, index, distance};
    return row;
  endfunction

  function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] sel,
                                   input logic [CFG_DATA_W-1:0] val);
    row_t row;
    row         = '0;
    row.kind    = ROW_REG;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send(input item_t it, input logic typed, input match_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_ch.valid       = 1'b1;
    in_ch.cmd         = it.cmd;
    in_ch.entry_index = it.idx;
    in_ch.red         = it.red;
    in_ch.green       = it.green;
    in_ch.blue        = it.blue;
    do @(posedge clk); while (!in_ch.ready);
    if (it.cmd == CMD_WRITE) pal_rgb[it.idx] = {it.red, it.green, it.blue};
    else pending_q.push_back(typed ? want : nearest_entry(it.red, it.green, it.blue));
    n_items++;
    burst_left--;
    @(negedge clk);
  endtask

  // Drain every pending result and let a last write settle before touching a register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                           input logic [CFG_DATA_W-1:0] val);
    in_ch.valid = 1'b0;
    burst_left  = 0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = sel;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (sel == CFG_MAX_DISTANCE) thresh = val[CHAN_W-1:0];
    else in_use = val[COUNT_W-1:0];
  endtask

  // Result receiver: stretches of steady, toggling, random and held-off ready
  initial begin : rx_pattern
    rdy_mode_t   mode;
    int unsigned len;
    out_ch.ready = 1'b0;
    forever begin
      mode = rdy_mode_t'($urandom_range(0, 3));
      len  = $urandom_range(4, 40);
      repeat (len) begin
        @(negedge clk);
        case (mode)
          RDY_ALWAYS:   out_ch.ready = 1'b1;
          RDY_TOGGLE:   out_ch.ready = ~out_ch.ready;
          RDY_RANDOM:   out_ch.ready = ($urandom_range(0, 3) != 0);
          RDY_HOLD_OFF: out_ch.ready = 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    match_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing pending: found=%0b index=%0d distance=%0d",
                 $time, out_ch.found, out_ch.match_index, out_ch.match_distance);
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        n_results++;
        if (want.found) n_found++;
        if (out_ch.found !== want.found) begin
          $display("%0t: found expected %0b actual %0b", $time, want.found, out_ch.found);
          mismatches++;
        end
        if (out_ch.match_index !== want.index) begin
          $display("%0t: match_index expected %0d actual %0d",
                   $time, want.index, out_ch.match_index);
          mismatches++;
        end
        if (out_ch.match_distance !== want.distance) begin
          $display("%0t: match_distance expected %0d actual %0d",
                   $time, want.distance, out_ch.match_distance);
          mismatches++;
        end
      end
    end
  end

  // Count cycles without any transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results pending",
               $time, QUIET_LIMIT, pending_q.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    item_t              it;
    logic [ENTRY_W-1:0] e;
    logic [CHAN_W-1:0]  new_max;
    logic [CFG_DATA_W-1:0] new_cnt;
    int unsigned        span, spread;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_WRITE;
    in_ch.entry_index = '0;
    in_ch.red         = '0;
    in_ch.green       = '0;
    in_ch.blue        = '0;

    // Empty palette first, then a small palette with duplicates for the tie rule
    steps.push_back(typed_row(8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0));
    steps.push_back(item_row(CMD_WRITE, 8'd0, 8'd0, 8'd0, 8'd0));
    steps.push_back(item_row(CMD_WRITE, 8'd1, 8'd255, 8'd255, 8'd255));
    steps.push_back(item_row(CMD_WRITE, 8'd2, 8'd10, 8'd20, 8'd30));
    steps.push_back(item_row(CMD_WRITE, 8'd3, 8'd10, 8'd20, 8'd30));
    steps.push_back(item_row(CMD_WRITE, 8'd4, 8'd30, 8'd20, 8'd10));
    steps.push_back(item_row(CMD_WRITE, 8'd255, 8'hAA, 8'h55, 8'hAA));
    steps.push_back(reg_row(CFG_PALETTE_COUNT, 9'd5));
    steps.push_back(typed_row(8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0));
    steps.push_back(typed_row(8'd255, 8'd255, 8'd255, 1'b1, 8'd1, 8'd0));
    steps.push_back(typed_row(8'd10, 8'd20, 8'd30, 1'b1, 8'd2, 8'd0));
    steps.push_back(item_row(CMD_QUERY, 8'hFF, 8'd12, 8'd22, 8'd32));
    steps.push_back(item_row(CMD_QUERY, 8'h00, 8'd128, 8'd128, 8'd128));
    steps.push_back(reg_row(CFG_MAX_DISTANCE, 9'd0));
    steps.push_back(item_row(CMD_QUERY, 8'h5A, 8'd11, 8'd20, 8'd30));
    steps.push_back(typed_row(8'd10, 8'd20, 8'd30, 1'b1, 8'd2, 8'd0));
    steps.push_back(reg_row(CFG_MAX_DISTANCE, 9'd255));
    steps.push_back(item_row(CMD_QUERY, 8'hA5, 8'd128, 8'd128, 8'd128));
    steps.push_back(item_row(CMD_QUERY, 8'h00, 8'd255, 8'd0, 8'd255));
    steps.push_back(reg_row(CFG_PALETTE_COUNT, 9'd1));
    steps.push_back(typed_row(8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 8'd255));
    steps.push_back(item_row(CMD_QUERY, 8'h00, 8'd0, 8'd0, 8'd0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (steps[k]) begin
      if (steps[k].kind == ROW_REG) write_reg(steps[k].reg_sel, steps[k].reg_val);
      else send(steps[k].item, steps[k].typed, steps[k].want);
    end

    // Load every entry so any palette count is legal from here on
    for (int k = 0; k < DEPTH; k++) begin
      it = '{CMD_WRITE, k[IDX_W-1:0], CHAN_W'($urandom), CHAN_W'($urandom),
             CHAN_W'($urandom)};
      send(it, 1'b0, '0);
    end

    while (n_items < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        0:       new_max = 8'd0;
        1:       new_max = 8'd255;
        2:       new_max = CHAN_W'($urandom_range(0, 255));
        default: new_max = CHAN_W'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 19))
        0:        new_cnt = 9'd0;
        1:        new_cnt = 9'd256;
        2:        new_cnt = CFG_DATA_W'($urandom_range(257, 511));
        3, 4, 5:  new_cnt = CFG_DATA_W'($urandom_range(17, 64));
        default:  new_cnt = CFG_DATA_W'($urandom_range(1, 16));
      endcase
      write_reg(CFG_MAX_DISTANCE, {1'b0, new_max});
      write_reg(CFG_PALETTE_COUNT, new_cnt);
      span = (new_cnt > DEPTH) ? DEPTH : new_cnt;

      // Long scans are slow: keep those phases short
      repeat ((span > 64) ? 8 : 40) begin
        if ($urandom_range(0, 9) < 3) begin
          it.cmd = CMD_WRITE;
          it.idx = (span == 0 || $urandom_range(0, 3) == 0) ?
                   IDX_W'($urandom_range(0, 255)) : IDX_W'($urandom_range(0, span - 1));
          if (span != 0 && $urandom_range(0, 2) == 0) begin
            // copy or near-copy of an entry in use, to force ties
            e        = pal_rgb[IDX_W'($urandom_range(0, span - 1))];
            spread   = $urandom_range(0, 3);
            it.red   = nudge(e[2*CHAN_W +: CHAN_W], spread);
            it.green = nudge(e[CHAN_W +: CHAN_W], spread);
            it.blue  = nudge(e[0 +: CHAN_W], spread);
          end else begin
            {it.red, it.green, it.blue} = ENTRY_W'($urandom);
          end
        end else begin
          it.cmd = CMD_QUERY;
          it.idx = IDX_W'($urandom);
          if (span != 0 && $urandom_range(0, 4) != 0) begin
            e = pal_rgb[IDX_W'($urandom_range(0, span - 1))];
            case ($urandom_range(0, 3))
              0:       spread = 0;
              1:       spread = int'(thresh);
              2:       spread = int'(thresh) + 4;
              default: spread = $urandom_range(0, 8);
            endcase
            it.red   = nudge(e[2*CHAN_W +: CHAN_W], spread);
            it.green = nudge(e[CHAN_W +: CHAN_W], spread);
            it.blue  = nudge(e[0 +: CHAN_W], spread);
          end else begin
            {it.red, it.green, it.blue} = ENTRY_W'($urandom);
          end
        end
        send(it, 1'b0, '0);
      end
    end

    in_ch.valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d items (palette writes and queries); checked %0d query results,",
             n_items, n_results);
    $display("%0d of them hits, over thresholds 0..255 and palette counts 0..511.", n_found);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
